[design/u16u8_pkg.sv]
// Shared types and constants of the UTF-16 to UTF-8 transcoder.
`timescale 1ns / 1ps
`default_nettype none
package u16u8_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [5:0] LEAD_TAG  = 6'b110110;
	localparam logic [5:0] TRAIL_TAG = 6'b110111;

	localparam logic [7:0] NUL_BYTE   = 8'h00;
	localparam logic [7:0] PFX_TWO    = 8'b1100_0000;
	localparam logic [7:0] PFX_THREE  = 8'b1110_0000;
	localparam logic [7:0] PFX_FOUR   = 8'b1111_0000;
	localparam logic [7:0] PFX_CONT   = 8'b1000_0000;

	localparam logic [20:0] SUPP_BASE = 21'h10000;

	// One classified input item: the bytes it causes, in output order.
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;
		logic            str_end;
	} u16u8_entry_t;

endpackage
`default_nettype wire

[design/u16u8_front.sv]
// Front end: accepts code units, pairs surrogates and builds the byte list of each item.
`timescale 1ns / 1ps
`default_nettype none
module u16u8_front
	import u16u8_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [15:0]  s_tdata,   // code_unit
	input  wire logic         s_tlast,   // string_end
	input  wire logic         q_full,
	output logic              q_push,
	output u16u8_entry_t      q_entry
);

	logic       pend_q;
	logic [9:0] held_q;

	logic            is_lead;
	logic            is_trail;
	logic            pair;
	logic            take;
	logic [20:0]     cp;
	logic [2:0][7:0] ub;
	logic [1:0]      ucnt;
	logic [2:0]      n;

	assign s_tready = !q_full;
	assign take     = s_tvalid && s_tready;
	assign is_lead  = s_tdata[15:10] == LEAD_TAG;
	assign is_trail = s_tdata[15:10] == TRAIL_TAG;
	assign pair     = pend_q && is_trail;
	assign cp       = {1'b0, held_q, s_tdata[9:0]} + SUPP_BASE;

	always_comb begin
		ub   = '0;
		ucnt = 2'd0;
		if (is_lead) begin
			ucnt = s_tlast ? 2'd1 : 2'd0;
		end else if (is_trail) begin
			ucnt = 2'd1;
		end else if (s_tdata < 16'h0080) begin
			ub[0] = s_tdata[7:0];
			ucnt  = 2'd1;
		end else if (s_tdata < 16'h0800) begin
			ub[0] = PFX_TWO | {3'b000, s_tdata[10:6]};
			ub[1] = PFX_CONT | {2'b00, s_tdata[5:0]};
			ucnt  = 2'd2;
		end else begin
			ub[0] = PFX_THREE | {4'b0000, s_tdata[15:12]};
			ub[1] = PFX_CONT | {2'b00, s_tdata[11:6]};
			ub[2] = PFX_CONT | {2'b00, s_tdata[5:0]};
			ucnt  = 2'd3;
		end
	end

	always_comb begin
		q_entry         = '0;
		q_entry.str_end = s_tlast;
		n               = 3'd0;
		if (pair) begin
			q_entry.bytes[0] = PFX_FOUR | {5'b00000, cp[20:18]};
			q_entry.bytes[1] = PFX_CONT | {2'b00, cp[17:12]};
			q_entry.bytes[2] = PFX_CONT | {2'b00, cp[11:6]};
			q_entry.bytes[3] = PFX_CONT | {2'b00, cp[5:0]};
			n                = 3'd4;
		end else if (pend_q) begin
			q_entry.bytes[0] = NUL_BYTE;
			q_entry.bytes[1] = ub[0];
			q_entry.bytes[2] = ub[1];
			q_entry.bytes[3] = ub[2];
			n                = {1'b0, ucnt} + 3'd1;
		end else begin
			q_entry.bytes[0] = ub[0];
			q_entry.bytes[1] = ub[1];
			q_entry.bytes[2] = ub[2];
			n                = {1'b0, ucnt};
		end
		q_entry.last_idx = 2'(n - 3'd1);
	end

	assign q_push = take && (n != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			held_q <= '0;
		end else if (take) begin
			if (is_lead && !s_tlast) begin
				pend_q <= 1'b1;
				held_q <= s_tdata[9:0];
			end else begin
				pend_q <= 1'b0;
				held_q <= '0;
			end
		end
	end

endmodule
`default_nettype wire

[design/u16u8_fifo.sv]
// Short queue of classified items between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module u16u8_fifo
	import u16u8_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire u16u8_entry_t push_entry,
	input  wire logic         pop,
	output logic              full,
	output logic              not_empty,
	output u16u8_entry_t      head
);

	u16u8_entry_t      mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full      = cnt_q == QCNT_W'(QUEUE_DEPTH);
	assign not_empty = cnt_q != '0;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

[design/u16u8_back.sv]
// Back end: sends each item's bytes one per cycle unless stalled, keeps the byte count.
`timescale 1ns / 1ps
`default_nettype none
module u16u8_back
	import u16u8_pkg::*;
#(
	parameter int unsigned COUNT_BITS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         q_valid,
	input  wire u16u8_entry_t q_head,
	output logic              q_pop,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [23:0]       m_tdata,   // out_byte, byte_total
	output logic              m_tlast,   // string_done
	output logic [0:0]        m_tuser    // run_last
);

	logic [1:0]            idx_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic                  valid_q;
	logic [7:0]            byte_q;
	logic [15:0]           total_q;
	logic                  run_last_q;
	logic                  done_q;

	logic                  load;
	logic                  last;
	logic [COUNT_BITS-1:0] cnt_next;

	assign load     = q_valid && (!valid_q || m_tready);
	assign last     = idx_q == q_head.last_idx;
	assign q_pop    = load && last;
	assign cnt_next = (&cnt_q) ? cnt_q : cnt_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= last ? 2'd0 : idx_q + 2'd1;
			cnt_q   <= (last && q_head.str_end) ? '0 : cnt_next;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q     <= q_head.bytes[idx_q];
			total_q    <= 16'(cnt_next);
			run_last_q <= last;
			done_q     <= last && q_head.str_end;
		end
	end

	assign m_tvalid   = valid_q;
	assign m_tdata    = {total_q, byte_q};
	assign m_tlast    = done_q;
	assign m_tuser[0] = run_last_q;

endmodule
`default_nettype wire

[design/utf16_to_utf8_transcoder.sv]
// Top level of the UTF-16 to UTF-8 transcoder.
`timescale 1ns / 1ps
`default_nettype none
// Each request on the slave side carries one UTF-16 code unit in s_tdata and the end-of-string
// flag in s_tlast. A leading surrogate is held until the next unit and causes no byte by itself
// unless it ends the string; every other unit causes one to four UTF-8 bytes, with a 0x00 byte
// standing in for an unpaired surrogate. The master side sends one byte per request: m_tdata
// holds the byte and the saturating count of bytes sent so far in the string, m_tuser marks the
// last byte of an input unit and m_tlast the last byte of the string. The output port sends one
// byte per cycle while m_tready is high, and a unit is taken every cycle while the two-entry
// queue between the classifier and the byte sender has room. When nothing is ahead of it, a
// unit's first byte passes through the queue and then the output register to the master side.
module utf16_to_utf8_transcoder
	import u16u8_pkg::*;
#(
	parameter int unsigned COUNT_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // code_unit
	input  wire logic        s_tlast,   // string_end
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // out_byte, byte_total
	output logic             m_tlast,   // string_done
	output logic [0:0]       m_tuser    // run_last
);

	logic         q_full;
	logic         q_push;
	logic         q_pop;
	logic         q_not_empty;
	u16u8_entry_t q_entry;
	u16u8_entry_t q_head;

	u16u8_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (q_entry)
	);

	u16u8_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.pop        (q_pop),
		.full       (q_full),
		.not_empty  (q_not_empty),
		.head       (q_head)
	);

	u16u8_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_not_empty),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
`default_nettype wire

[design/u16u8_checker.sv]
// Port-level assertions for the UTF-16 to UTF-8 transcoder, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none
module u16u8_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [15:0] s_tdata,
	input wire logic        s_tlast,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [23:0] m_tdata,
	input wire logic        m_tlast,
	input wire logic [0:0]  m_tuser
);

	// A waiting input request keeps its contents until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tlast))
		else $error("waiting input request changed");

	// A stalled output request keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("stalled output request changed");

	// The end of a string is always the last byte of its unit.
	a_done_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser[0])
		else $error("string end without unit end");

	// A multibyte lead byte is never the last byte of its unit.
	a_lead_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[7:6] == 2'b11 |-> !m_tuser[0])
		else $error("multibyte lead byte marked as last of unit");

	// Reset empties the output register.
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("output valid during reset");

endmodule

bind utf16_to_utf8_transcoder u16u8_checker u_checker (.*);
`default_nettype wire
